// ===== design/assert_macros.svh =====
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define BLH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BLH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/blh_pkg.sv =====
package blh_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int NUM_THRESH      = 5;
	localparam int THRESH_BITS     = 12;
	localparam int HYST_BITS       = 8;
	localparam int LEVEL_BITS      = 3;
	localparam int FE_BITS         = 11;
	localparam int VOLT_BITS       = 14;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 12;

	localparam int LEVEL_TOP     = 4;
	localparam int FRONT_END_MAX = 2047;
	localparam int VOLT_MAX      = 16383;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_0 = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_4 = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_HYSTERESIS  = 3'd5;

	typedef logic [THRESH_BITS-1:0] thresh_t;
	typedef thresh_t                thresh_arr_t [NUM_THRESH];
	typedef logic [HYST_BITS-1:0]   hyst_t;
	typedef logic [LEVEL_BITS-1:0]  level_t;

	localparam thresh_t THRESH_RESET [NUM_THRESH] = '{
		12'd1125, 12'd1194, 12'd1262, 12'd1364, 12'd1432
	};
	localparam hyst_t HYST_RESET = 8'd10;

	// level tracking state handed to the evaluation logic
	typedef struct packed {
		logic   first_pending;
		level_t level;
	} lvl_state_t;

endpackage

// ===== design/battery_level_hysteresis_top.sv =====
// Battery level quantizer with hysteresis. Each accepted ADC sample yields one
// result: a battery level 0..4 from five ascending thresholds (counting stops at
// the first threshold not exceeded), a front-end value of sample*6/5 saturated at
// 2047, and the voltage in Q10 (sample*3). The first sample after reset sets the
// level directly; later, a higher level needs the sample at or above the lower
// boundary of that level plus the hysteresis, and a lower level needs the sample
// at or below the upper boundary of that level minus the hysteresis (always
// taken when that boundary is below the hysteresis). A sample passes the input
// register, then the result register, whose level feeds back; one sample is
// taken every cycle unless the result channel stalls. Thresholds and hysteresis
// are to be written by the user through the configuration port (0..4 thresholds,
// 5 hysteresis, others ignored) while the block is idle; this is not enforced.
`include "assert_macros.svh"

module battery_level_hysteresis_top import blh_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// sample channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SAMPLE_BITS-1:0]   sample,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [LEVEL_BITS-1:0]    battery_level,
	output logic [FE_BITS-1:0]       front_end_value,
	output logic [VOLT_BITS-1:0]     voltage_q10,
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	thresh_arr_t              threshold_q;
	hyst_t                    hysteresis_q;
	logic                     valid_s1;
	logic [SAMPLE_BITS-1:0]   sample_s1;
	logic                     out_valid_q;
	level_t                   current_level_q;
	logic                     first_pending_q;
	logic [FE_BITS-1:0]       fe_q;
	logic [VOLT_BITS-1:0]     volt_q;
	logic                     out_free;
	logic                     adv_s1;
	logic                     in_xfer;
	lvl_state_t               lvl_state;
	level_t                   next_level;
	logic [FE_BITS-1:0]       fe_next;
	logic [VOLT_BITS-1:0]     volt_next;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESH_RESET;
			hysteresis_q <= HYST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index inside {[REG_THRESHOLD_0:REG_THRESHOLD_4]}) begin
				threshold_q[cfg_index] <= cfg_data[THRESH_BITS-1:0];
			end else if (cfg_index == REG_HYSTERESIS) begin
				hysteresis_q <= cfg_data[HYST_BITS-1:0];
			end
		end
	end

	// pipeline flow control
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1 <= sample;
		end
	end

	// evaluation of the registered sample
	assign lvl_state = '{first_pending: first_pending_q, level: current_level_q};

	blh_eval #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_eval (
		.sample          (sample_s1),
		.threshold       (threshold_q),
		.hysteresis      (hysteresis_q),
		.state           (lvl_state),
		.next_level      (next_level),
		.front_end_value (fe_next),
		.voltage_q10     (volt_next)
	);

	// level state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			current_level_q <= '0;
			first_pending_q <= 1'b1;
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (adv_s1) begin
				current_level_q <= next_level;
				first_pending_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fe_q   <= fe_next;
			volt_q <= volt_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign battery_level   = current_level_q;
	assign front_end_value = fe_q;
	assign voltage_q10     = volt_q;

	// checks
	`BLH_ASSERT_IMP(a_level_range, out_valid_q, current_level_q <= level_t'(LEVEL_TOP), "level out of range")
	`BLH_ASSERT_NXT(a_first_cleared, adv_s1, !first_pending_q && out_valid_q, "first sample not retired")
	`BLH_ASSERT_NXT(a_level_hold, !adv_s1, $stable(current_level_q), "level changed without a transfer")
	`BLH_ASSERT_IMP(a_first_no_result, first_pending_q, !out_valid_q, "result present before first sample")

endmodule

// ===== design/blh_eval.sv =====
module blh_eval import blh_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic [SAMPLE_BITS-1:0] sample,
	input  thresh_arr_t            threshold,
	input  hyst_t                  hysteresis,
	input  lvl_state_t             state,
	output level_t                 next_level,
	output logic [FE_BITS-1:0]     front_end_value,
	output logic [VOLT_BITS-1:0]   voltage_q10
);

	// compare width: sample or threshold plus margin, whichever is wider
	localparam int CW = (SAMPLE_BITS > THRESH_BITS + 1) ? SAMPLE_BITS : THRESH_BITS + 1;
	// voltage product width and saturation compare width
	localparam int VW = SAMPLE_BITS + 2;
	localparam int VX = (VW > VOLT_BITS) ? VW : VOLT_BITS;
	// smallest sample whose 6/5 scale exceeds the front-end maximum
	localparam int FE_SAT = ((FRONT_END_MAX + 1) * 5 + 5) / 6;
	// floor(x / 5) as (x * 13108) >> 16, exact for x below 16384
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_5     = ((1 << RECIP_SHIFT) + 4) / 5;
	localparam int XW          = 14;
	localparam int PW          = XW + 15;

	logic [CW-1:0]        s_w;
	logic [NUM_THRESH-1:0] gt;
	level_t               cand;
	thresh_t              th_rise;
	thresh_t              th_fall;
	logic [CW-1:0]        rise_lim;
	logic                 rise_ok;
	logic                 fall_ok;
	logic [FE_BITS-1:0]   s_lo;
	logic [XW-1:0]        x6;
	logic [PW-1:0]        prod;
	logic [VX-1:0]        volt_full;

	assign s_w = CW'(sample);

	// threshold comparators
	always_comb begin
		for (int i = 0; i < NUM_THRESH; i++) begin
			gt[i] = s_w > CW'(threshold[i]);
		end
	end

	// candidate: first threshold not exceeded, clamped to the top level
	always_comb begin
		cand = level_t'(LEVEL_TOP);
		for (int i = NUM_THRESH - 1; i >= 0; i--) begin
			if (!gt[i]) begin
				cand = level_t'(i);
			end
		end
	end

	// hysteresis checks
	assign th_rise  = threshold[cand - level_t'(1)];
	assign th_fall  = threshold[cand];
	assign rise_lim = CW'(th_rise) + CW'(hysteresis);
	assign rise_ok  = s_w >= rise_lim;
	assign fall_ok  = (th_fall < thresh_t'(hysteresis)) ||
		(s_w <= CW'(th_fall - thresh_t'(hysteresis)));

	// level update
	always_comb begin
		next_level = state.level;
		if (state.first_pending) begin
			next_level = cand;
		end else if (cand > state.level) begin
			if (rise_ok) begin
				next_level = cand;
			end
		end else if (cand < state.level) begin
			if (fall_ok) begin
				next_level = cand;
			end
		end
	end

	// front-end scale by 6/5 with saturation
	assign s_lo = sample[FE_BITS-1:0];
	assign x6   = {1'b0, s_lo, 2'b00} + {2'b00, s_lo, 1'b0};
	assign prod = PW'(x6) * PW'(RECIP_5);
	always_comb begin
		if (s_w >= CW'(FE_SAT)) begin
			front_end_value = FE_BITS'(FRONT_END_MAX);
		end else begin
			front_end_value = prod[RECIP_SHIFT +: FE_BITS];
		end
	end

	// voltage in q10 is three times the sample, saturated
	assign volt_full = VX'(sample) + VX'({sample, 1'b0});
	always_comb begin
		if (volt_full > VX'(VOLT_MAX)) begin
			voltage_q10 = VOLT_BITS'(VOLT_MAX);
		end else begin
			voltage_q10 = volt_full[VOLT_BITS-1:0];
		end
	end

endmodule

// ===== bench/tb_battery_level_hysteresis_top.sv =====
module tb_battery_level_hysteresis_top;
	timeunit 1ns;
	timeprecision 1ps;
	import blh_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int NUM_PHASES      = 12;
	localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS_DEF) - 1;
	localparam int NUM_CFG_FIELDS  = NUM_THRESH + 1;

	// indexes past the hysteresis register are decoded as no-ops
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = REG_HYSTERESIS + 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = '1;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef logic [SAMPLE_BITS_DEF-1:0] sample_t;

	typedef struct packed {
		level_t               level;
		logic [FE_BITS-1:0]   fe;
		logic [VOLT_BITS-1:0] volt;
	} batt_result_t;

	// one directed transfer: sample, pinned flag, pinned result
	typedef struct packed {
		sample_t      smp;
		logic         pinned;
		batt_result_t res;
	} dir_row_t;

	// directed walk over the reset thresholds (hysteresis 10)
	localparam int NUM_DIRECTED = 17;
	localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		{12'd0,    1'b1, 3'd0, 11'd0,    14'd0},     // first sample sets level
		{12'd4095, 1'b1, 3'd4, 11'd2047, 14'd12285}, // full scale, clamped level
		{12'd1300, 1'b0, 28'd0},
		{12'd1365, 1'b0, 28'd0},                     // short of rise margin
		{12'd1374, 1'b0, 28'd0},                     // exactly on rise margin
		{12'd1360, 1'b0, 28'd0},                     // short of fall margin
		{12'd1354, 1'b0, 28'd0},                     // exactly on fall margin
		{12'd1262, 1'b0, 28'd0},
		{12'd1252, 1'b0, 28'd0},
		{12'd1125, 1'b0, 28'd0},
		{12'd1115, 1'b0, 28'd0},
		{12'd1705, 1'b1, 3'd4, 11'd2046, 14'd5115},  // front end just below its maximum
		{12'd1706, 1'b1, 3'd4, 11'd2047, 14'd5118},  // last unsaturated front end, at its maximum
		{12'd1432, 1'b0, 28'd0},
		{12'd1,    1'b1, 3'd0, 11'd1,    14'd3},
		{12'd2048, 1'b0, 28'd0},
		{12'd5,    1'b0, 28'd0}
	};

	// fixed register sets: thresholds 0..4, then hysteresis (raw write data)
	localparam int NUM_FIXED = 7;
	localparam int FIXED_CFG [NUM_FIXED][NUM_CFG_FIELDS] = '{
		'{1125, 1194, 1262, 1364, 1432, 10},
		'{0,    0,    0,    0,    0,    0},
		'{4095, 4095, 4095, 4095, 4095, 4095}, // upper data bits must be dropped
		'{100,  200,  300,  400,  500,  255},  // boundary below margin
		'{1000, 2000, 3000, 4000, 4094, 255},  // boundary plus margin past 12 bits
		'{2000, 500,  3000, 100,  3500, 40},   // unordered boundaries
		'{800,  1600, 2400, 3200, 4000, 0}
	};

	logic                     clk;
	logic                     arst_n          = 1'b0;
	logic                     in_valid        = 1'b0;
	logic                     in_stall;
	sample_t                  sample          = '0;
	logic                     out_valid;
	logic                     out_stall       = 1'b0;
	level_t                   battery_level;
	logic [FE_BITS-1:0]       front_end_value;
	logic [VOLT_BITS-1:0]     voltage_q10;
	logic                     cfg_valid       = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index       = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data        = '0;

	// shadow of the block's registers and level state
	thresh_t bound [NUM_THRESH];
	hyst_t   margin;
	level_t  level_now;
	logic    level_unset;

	batt_result_t result_fifo [$];
	logic         pin_en             = 1'b0;
	batt_result_t pin_res            = '0;
	int           sender_gap_pct     = 0;
	int           receiver_stall_pct = 0;
	int           fail_count         = 0;
	int           quiet_cycles       = 0;
	int           walk_pos           = 0;

	battery_level_hysteresis_top dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.sample,
		.out_valid,
		.out_stall,
		.battery_level,
		.front_end_value,
		.voltage_q10,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// level tracking with hysteresis, plus the two scaled outputs
	function automatic batt_result_t quantize_sample(sample_t s);
		int           cand;
		int           fe;
		int           volt;
		batt_result_t r;
		cand = 0;
		while (cand < NUM_THRESH && s > bound[cand])
			cand++;
		if (cand > LEVEL_TOP)
			cand = LEVEL_TOP;
		if (level_unset) begin
			level_unset = 1'b0;
			level_now = level_t'(cand);
		end else if (cand > int'(level_now)) begin
			// rise margin is formed at full width
			if (int'(s) >= int'(bound[cand-1]) + int'(margin))
				level_now = level_t'(cand);
		end else if (cand < int'(level_now)) begin
			// a boundary below the margin always lets the level fall
			if (int'(bound[cand]) < int'(margin) ||
			    int'(s) <= int'(bound[cand]) - int'(margin))
				level_now = level_t'(cand);
		end
		fe = int'(s) * 6 / 5;
		if (fe > FRONT_END_MAX)
			fe = FRONT_END_MAX;
		volt = int'(s) * 3;
		if (volt > VOLT_MAX)
			volt = VOLT_MAX;
		r.level = level_now;
		r.fe    = fe[FE_BITS-1:0];
		r.volt  = volt[VOLT_BITS-1:0];
		return r;
	endfunction

	// mostly samples around the boundaries and slow walks across them
	function automatic sample_t pick_sample();
		int r;
		int k;
		int v;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			case ($urandom_range(0, 3))
				0: v = 0;
				1: v = SAMPLE_MAX;
				2: v = 1 << $urandom_range(0, SAMPLE_BITS_DEF - 1);
				default: v = SAMPLE_MAX ^ (1 << $urandom_range(0, SAMPLE_BITS_DEF - 1));
			endcase
		end else if (r < 50) begin
			k = $urandom_range(0, NUM_THRESH - 1);
			v = int'(bound[k]) + int'($urandom_range(0, 2 * int'(margin) + 4))
				- int'(margin) - 2;
		end else if (r < 80) begin
			v = walk_pos + int'($urandom_range(0, 2 * int'(margin) + 6)) - int'(margin) - 3;
		end else begin
			v = $urandom_range(0, SAMPLE_MAX);
		end
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		walk_pos = v;
		return sample_t'(v);
	endfunction

	// receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
	end

	// predict on sample transfers, check on result transfers, watchdog
	always @(posedge clk) begin : monitor
		batt_result_t want;
		if (in_valid && !in_stall) begin
			want = quantize_sample(sample);
			result_fifo.push_back(pin_en ? pin_res : want);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (result_fifo.size() == 0) begin
				$error("result transfer with no sample outstanding: battery_level %0d",
					battery_level);
				fail_count++;
			end else begin
				want = result_fifo.pop_front();
				if (battery_level !== want.level) begin
					$error("battery_level: expected %0d, got %0d", want.level, battery_level);
					fail_count++;
				end
				if (front_end_value !== want.fe) begin
					$error("front_end_value: expected %0d, got %0d", want.fe, front_end_value);
					fail_count++;
				end
				if (voltage_q10 !== want.volt) begin
					$error("voltage_q10: expected %0d, got %0d", want.volt, voltage_q10);
					fail_count++;
				end
			end
		end
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic set_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				sender_gap_pct = 0;
				receiver_stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_gap_pct = 64;
				receiver_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_gap_pct = 0;
				receiver_stall_pct = 64;
			end
			default: begin
				sender_gap_pct = 16;
				receiver_stall_pct = 16;
			end
		endcase
	endtask

	// one sample transfer; valid stays high on return
	task automatic send_sample(sample_t s, logic pinned, batt_result_t res);
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		pin_en   <= pinned;
		pin_res  <= res;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		// advance the clock so the last sample transfer is surely in the queue
		@(posedge clk);
		while (result_fifo.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register transfer; valid is lowered by the caller
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_THRESHOLD_4)
			bound[idx] = data;
		else if (idx == REG_HYSTERESIS)
			margin = data[HYST_BITS-1:0];
	endtask

	task automatic load_config(int p);
		int val [NUM_CFG_FIELDS];
		int j;
		if (p < NUM_FIXED) begin
			for (j = 0; j < NUM_CFG_FIELDS; j++)
				val[j] = FIXED_CFG[p][j];
		end else begin
			if ($urandom_range(0, 1)) begin
				val[0] = $urandom_range(0, 800);
				for (j = 1; j < NUM_THRESH; j++) begin
					val[j] = val[j-1] + int'($urandom_range(0, 800));
					if (val[j] > SAMPLE_MAX)
						val[j] = SAMPLE_MAX;
				end
			end else begin
				for (j = 0; j < NUM_THRESH; j++)
					val[j] = $urandom_range(0, SAMPLE_MAX);
			end
			val[NUM_THRESH] = $urandom_range(0, (1 << CFG_DATA_BITS) - 1);
		end
		for (j = 0; j < NUM_THRESH; j++)
			write_reg(REG_THRESHOLD_0 + j[CFG_IDX_BITS-1:0], val[j][CFG_DATA_BITS-1:0]);
		write_reg(REG_HYSTERESIS, val[NUM_THRESH][CFG_DATA_BITS-1:0]);
		write_reg(CFG_IDX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
			CFG_DATA_BITS'($urandom_range(0, (1 << CFG_DATA_BITS) - 1)));
		cfg_valid <= 1'b0;
	endtask

	// stimulus
	initial begin : stimulus
		int i;
		int p;
		int k;
		for (i = 0; i < NUM_THRESH; i++)
			bound[i] = THRESH_RESET[i];
		margin = HYST_RESET;
		level_now = '0;
		level_unset = 1'b1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk at reset settings
		set_idle(IDLE_NONE);
		for (i = 0; i < NUM_DIRECTED; i++)
			send_sample(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].res);

		// random phases, one register set and idle mode each
		for (p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			set_idle(IDLE_NONE);
			load_config(p);
			set_idle(idle_mode_t'(p % 4));
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (p == 2 && k == ITEMS_PER_PHASE / 2)
					drain_results();
				send_sample(pick_sample(), 1'b0, '0);
			end
		end
		drain_results();

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/blh_pkg.sv
design/blh_eval.sv
design/battery_level_hysteresis_top.sv
bench/tb_battery_level_hysteresis_top.sv
